// ===== hw/rtl/sso_pkg.sv =====
// Package for the second-order state observer: payload structs, register indexes,
// state machine types and the 32-bit saturation helper.
// No dependencies; every other file of the block imports it.
package sso_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAIN_W    = 31;
  localparam int unsigned MUL_A_W   = 34;
  localparam int unsigned MUL_B_W   = 32;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_GAIN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_GAIN  = 4'd1;

  localparam logic signed [PROD_W-1:0] SAT_HI = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO = {{(PROD_W-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] control_input;
    logic signed [DATA_W-1:0] measurement;
    logic signed [DATA_W-1:0] input_gain;
  } sso_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] state_estimate;
    logic signed [DATA_W-1:0] disturbance_estimate;
  } sso_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_MBU,
    ST_RBU,
    ST_SBU,
    ST_MGE,
    ST_RGE,
    ST_SGE,
    ST_SUM,
    ST_MS,
    ST_RS,
    ST_Z1,
    ST_FAL,
    ST_MSQ,
    ST_SQST,
    ST_SQRT,
    ST_MG,
    ST_RG,
    ST_SG,
    ST_MGH,
    ST_RGH,
    ST_Z2
  } sso_state_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_FIN
  } sso_sqrt_state_e;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sso_sqrt.sv =====
// Iterative integer square root, rounded to nearest, two radicand bits per cycle.
// Depends on sso_pkg for the sequencer state type.
module sso_sqrt import sso_pkg::*; #(
  parameter int unsigned WIDTH = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WIDTH-1:0]     operand_i,
  output logic                 done_o,
  output logic [WIDTH/2:0]     root_o
);

  localparam int unsigned RW = WIDTH / 2 + 1;

  sso_sqrt_state_e state_q, state_d;
  logic [WIDTH-1:0] n_q;
  logic [WIDTH-1:0] res_q;
  logic [WIDTH-1:0] bit_q;
  logic [WIDTH:0]   trial;
  logic             fits;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};
  assign fits  = {1'b0, n_q} >= trial;

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    root_o  = RW'(res_q) + RW'(n_q > res_q);
    case (state_q)
      SQ_IDLE: begin
        if (start_i) begin
          state_d = SQ_RUN;
        end
      end
      SQ_RUN: begin
        // The weight bit reaches bit zero on the last digit.
        if (bit_q[0]) begin
          state_d = SQ_FIN;
        end
      end
      SQ_FIN: begin
        done_o  = 1'b1;
        state_d = SQ_IDLE;
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SQ_IDLE && start_i) begin
      n_q   <= operand_i;
      res_q <= '0;
      bit_q <= WIDTH'(1) << (WIDTH - 2);
    end else if (state_q == SQ_RUN) begin
      if (fits) begin
        n_q   <= n_q - trial[WIDTH-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ===== hw/rtl/second_order_state_observer_core.sv =====
// Second-order extended state observer with a nonlinear (fal) disturbance correction.
// Depends on sso_pkg and on sso_sqrt for the square root of the fal term.
//
// Usage: each input beat carries control input u, measurement y and input gain b.
// The block forms e = z1 - y, updates the state estimate z1 with the linear gain
// and the disturbance estimate z2 with the fal term, and returns one output beat
// with the new z1 and z2. All values are signed fixed point with FRAC_BITS
// fraction bits, saturated to 32 bits.
// One shared 34x32 multiplier and its rounding stage are sequenced by a state
// machine; the square root runs two radicand bits per cycle.
// The square root works on SQW = 32 + FRAC_BITS bits, rounded up to even. When |e|
// is within delta, the steps MSQ and SQST first form the radicand in the multiplier.
// in_stall_o is high while an item is worked on, so a new beat is taken at the
// earliest in the cycle after the result is registered.
// A finished result waits in the output register; if the receiver stalls and a
// second result is ready, the sequencer holds at its last step until the first
// beat is taken. Reset clears both estimates to zero and loads the gains with
// 100.0 and 300.0. Configuration writes are always ready and are ignored for
// unknown indexes.
module second_order_state_observer_core import sso_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sso_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sso_out_t             out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SQW = ((DATA_W + FRAC_BITS + 1) / 2) * 2;
  localparam int unsigned RW  = SQW / 2 + 1;
  localparam int unsigned FW  = RW + 1;

  localparam logic [DATA_W-1:0] STEP_H = DATA_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [DATA_W-1:0] DELTA  = DATA_W'(((1 << FRAC_BITS) + 10) / 20);
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [GAIN_W-1:0] STATE_GAIN_RST = GAIN_W'(100) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] DIST_GAIN_RST  = GAIN_W'(300) << FRAC_BITS;

  sso_state_e state_q, state_d;

  logic [GAIN_W-1:0]         gain_state_q;
  logic [GAIN_W-1:0]         gain_dist_q;
  logic signed [DATA_W-1:0]  z1_q, z2_q;
  logic signed [DATA_W-1:0]  u_q, y_q, b_q;
  logic signed [DATA_W-1:0]  e_q, bu_q, ge_q, z1n_q, g_q;
  logic signed [MUL_A_W-1:0] s_q;
  logic signed [FW-1:0]      fal_q;
  logic signed [PROD_W-1:0]  prod_q, rnd_q;
  logic                      out_valid_q;
  sso_out_t                  out_data_q;

  logic                      in_accept;
  logic                      load_out;
  logic [DATA_W-1:0]         e_mag;
  logic                      e_big;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_c, rnd_c;
  logic signed [PROD_W-1:0]  err_dif, z1_sum, z2_dif;
  logic signed [MUL_A_W-1:0] sum_c;
  logic signed [FW-1:0]      fal_c;
  logic                      sq_start;
  logic [SQW-1:0]            sq_operand;
  logic                      sq_done;
  logic [RW-1:0]             sq_root;

  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign e_mag = e_q[DATA_W-1] ? DATA_W'(-e_q) : DATA_W'(e_q);
  assign e_big = e_mag > DELTA;

  assign err_dif = PROD_W'(z1_q) - PROD_W'(y_q);
  assign sum_c   = MUL_A_W'(z2_q) + MUL_A_W'(bu_q) - MUL_A_W'(ge_q);
  assign z1_sum  = PROD_W'(z1_q) + rnd_q;
  assign z2_dif  = PROD_W'(z2_q) - rnd_q;

  // Round half away from zero: a negative product takes one less than half.
  assign prod_c = mul_a * mul_b;
  assign rnd_c  = (prod_q + (prod_q[PROD_W-1] ? HALF - 1 : HALF)) >>> FRAC_BITS;

  assign fal_c = e_q[DATA_W-1] ? -$signed({1'b0, sq_root}) : $signed({1'b0, sq_root});

  // Outside delta the radicand is |e| scaled up; inside it is 20 * e^2 from the multiplier.
  assign sq_start   = (state_q == ST_FAL && e_big) || state_q == ST_SQST;
  assign sq_operand = (state_q == ST_FAL) ? (SQW'(e_mag) << FRAC_BITS) : prod_q[SQW-1:0];

  sso_sqrt #(
    .WIDTH(SQW)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .operand_i (sq_operand),
    .done_o    (sq_done),
    .root_o    (sq_root)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MBU: begin
        mul_a = MUL_A_W'(b_q);
        mul_b = u_q;
      end
      ST_MGE: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = $signed({1'b0, gain_state_q});
      end
      ST_MS: begin
        mul_a = s_q;
        mul_b = $signed(STEP_H);
      end
      ST_MSQ: begin
        mul_a = $signed(MUL_A_W'({e_mag, 4'b0}) + MUL_A_W'({e_mag, 2'b0}));
        mul_b = $signed(e_mag);
      end
      ST_MG: begin
        mul_a = MUL_A_W'(fal_q);
        mul_b = $signed({1'b0, gain_dist_q});
      end
      ST_MGH: begin
        mul_a = MUL_A_W'(g_q);
        mul_b = $signed(STEP_H);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = (state_q != ST_IDLE);
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ERR;
        end
      end
      ST_ERR:  state_d = ST_MBU;
      ST_MBU:  state_d = ST_RBU;
      ST_RBU:  state_d = ST_SBU;
      ST_SBU:  state_d = ST_MGE;
      ST_MGE:  state_d = ST_RGE;
      ST_RGE:  state_d = ST_SGE;
      ST_SGE:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_MS;
      ST_MS:   state_d = ST_RS;
      ST_RS:   state_d = ST_Z1;
      ST_Z1:   state_d = ST_FAL;
      ST_FAL: begin
        state_d = e_big ? ST_SQRT : ST_MSQ;
      end
      ST_MSQ:  state_d = ST_SQST;
      ST_SQST: state_d = ST_SQRT;
      ST_SQRT: begin
        if (sq_done) begin
          state_d = ST_MG;
        end
      end
      ST_MG:   state_d = ST_RG;
      ST_RG:   state_d = ST_SG;
      ST_SG:   state_d = ST_MGH;
      ST_MGH:  state_d = ST_RGH;
      ST_RGH:  state_d = ST_Z2;
      ST_Z2: begin
        if (!(out_valid_q && out_stall_i)) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gain_state_q <= STATE_GAIN_RST;
      gain_dist_q  <= DIST_GAIN_RST;
      z1_q         <= '0;
      z2_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_STATE_GAIN: gain_state_q <= cfg_data_i[GAIN_W-1:0];
          CFG_DIST_GAIN:  gain_dist_q  <= cfg_data_i[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (load_out) begin
        z1_q        <= z1n_q;
        z2_q        <= sat32(z2_dif);
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      u_q <= in_data_i.control_input;
      y_q <= in_data_i.measurement;
      b_q <= in_data_i.input_gain;
    end
    if (load_out) begin
      out_data_q.state_estimate       <= z1n_q;
      out_data_q.disturbance_estimate <= sat32(z2_dif);
    end
    case (state_q)
      ST_ERR:  e_q <= sat32(err_dif);
      ST_MBU, ST_MGE, ST_MS, ST_MSQ, ST_MG, ST_MGH: begin
        prod_q <= prod_c;
      end
      ST_RBU, ST_RGE, ST_RS, ST_RG, ST_RGH: begin
        rnd_q <= rnd_c;
      end
      ST_SBU:  bu_q  <= sat32(rnd_q);
      ST_SGE:  ge_q  <= sat32(rnd_q);
      ST_SUM:  s_q   <= sum_c;
      ST_Z1:   z1n_q <= sat32(z1_sum);
      ST_SQRT: begin
        if (sq_done) begin
          fal_q <= fal_c;
        end
      end
      ST_SG:   g_q <= sat32(rnd_q);
      default: begin
      end
    endcase
  end

endmodule

// ===== sim/observer_estimate_checker.sv =====
`timescale 1ns / 1ps
// Checker for the second-order state observer core: predicts every estimate beat from
// the accepted sample beats and register writes, and compares it field by field.
// Depends on sso_pkg for the payload structs, widths and register indexes.
module observer_estimate_checker import sso_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  sso_in_t                  in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  sso_out_t                 out_data_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  output int                       fail_count_o,
  output int                       outstanding_o,
  output int                       checked_o,
  output logic signed [DATA_W-1:0] predicted_state_o
);

  localparam longint UNIT      = longint'(1) << FRAC_BITS;
  localparam longint STEP      = (UNIT + 50) / 100;
  localparam longint DELTA     = (UNIT + 10) / 20;
  localparam longint HALF_LSB  = longint'(1) << (FRAC_BITS - 1);
  localparam longint WORD_MAX  = 64'sd2147483647;
  localparam longint WORD_MIN  = -64'sd2147483648;
  localparam longint GAIN_RST1 = longint'(100) << FRAC_BITS;
  localparam longint GAIN_RST2 = longint'(300) << FRAC_BITS;

  longint   z_state;
  longint   z_disturbance;
  longint   state_gain;
  longint   disturbance_gain;
  sso_out_t expected_estimates[$];
  int       fails;
  int       checked;

  function automatic longint clamp32(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // Drops the fraction bits, rounding to nearest with ties away from zero.
  function automatic longint round_frac(input longint x);
    longint mag;
    longint r;
    mag = (x < 0) ? -x : x;
    r   = (mag + HALF_LSB) >>> FRAC_BITS;
    return (x < 0) ? -r : r;
  endfunction

  function automatic longint root_nearest(input longint n);
    longint r;
    longint t;
    r = 0;
    for (int b = 30; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    // Round up when n lies above (r + 0.5)^2.
    if (n - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic longint fal_correction(input longint e);
    longint mag;
    longint r;
    mag = (e < 0) ? -e : e;
    if (mag > DELTA) begin
      r = root_nearest(mag << FRAC_BITS);
    end else begin
      r = root_nearest(20 * mag * mag);
    end
    return (e < 0) ? -r : r;
  endfunction

  function automatic sso_out_t next_estimates(input sso_in_t sample);
    longint   u, y, b, e, bu, ge, total, z1n, g, z2n;
    sso_out_t res;
    u     = longint'($signed(sample.control_input));
    y     = longint'($signed(sample.measurement));
    b     = longint'($signed(sample.input_gain));
    e     = clamp32(z_state - y);
    bu    = clamp32(round_frac(b * u));
    ge    = clamp32(round_frac(state_gain * e));
    total = z_disturbance + bu - ge;
    z1n   = clamp32(z_state + round_frac(total * STEP));
    g     = clamp32(round_frac(disturbance_gain * fal_correction(e)));
    z2n   = clamp32(z_disturbance - round_frac(g * STEP));
    z_state       = z1n;
    z_disturbance = z2n;
    res.state_estimate       = z1n[DATA_W-1:0];
    res.disturbance_estimate = z2n[DATA_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    sso_out_t want;
    if (!rst_ni) begin
      z_state           = 0;
      z_disturbance     = 0;
      state_gain        = GAIN_RST1;
      disturbance_gain  = GAIN_RST2;
      fails             = 0;
      checked           = 0;
      expected_estimates.delete();
      fail_count_o      <= 0;
      outstanding_o     <= 0;
      checked_o         <= 0;
      predicted_state_o <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_STATE_GAIN: state_gain = longint'(cfg_data_i[GAIN_W-1:0]);
          CFG_DIST_GAIN:  disturbance_gain = longint'(cfg_data_i[GAIN_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_estimates.push_back(next_estimates(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_estimates.size() == 0) begin
          fails++;
          $display("%0t: estimate beat %h arrived with no sample outstanding", $time,
                   out_data_i);
        end else begin
          want = expected_estimates.pop_front();
          checked++;
          if (want.state_estimate !== out_data_i.state_estimate) begin
            fails++;
            $display("%0t: state_estimate expected %0d, got %0d", $time,
                     want.state_estimate, out_data_i.state_estimate);
          end
          if (want.disturbance_estimate !== out_data_i.disturbance_estimate) begin
            fails++;
            $display("%0t: disturbance_estimate expected %0d, got %0d", $time,
                     want.disturbance_estimate, out_data_i.disturbance_estimate);
          end
        end
      end
      fail_count_o      <= fails;
      outstanding_o     <= expected_estimates.size();
      checked_o         <= checked;
      predicted_state_o <= z_state[DATA_W-1:0];
    end
  end

endmodule

// ===== sim/second_order_state_observer_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the state observer testbench: clock, reset, sample and register stimulus,
// receiver stalls, watchdog and verdict.
// Depends on sso_pkg, the core and observer_estimate_checker.
module second_order_state_observer_core_tb;
  import sso_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam longint      UNIT        = longint'(1) << FRAC_BITS;
  localparam longint      DELTA       = (UNIT + 10) / 20;
  localparam longint      WORD_MAX    = 64'sd2147483647;
  localparam longint      WORD_MIN    = -64'sd2147483648;
  localparam int          DIRECTED    = 18;
  localparam int          SETTINGS_N  = 8;
  localparam int          PER_SETTING = 230;
  localparam int          LONG_HOLD   = 400;
  localparam int          HOLD_AFTER  = DIRECTED + 200;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          TAIL_CYCLES = 60;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  sso_in_t                  in_data   = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DATA_W-1:0]        cfg_data  = '0;
  logic                     in_stall;
  logic                     out_valid;
  sso_out_t                 out_data;
  logic                     cfg_ready;
  int                       fail_count;
  int                       outstanding;
  int                       checked;
  logic signed [DATA_W-1:0] predicted_state;
  int                       samples_sent = 0;
  int                       quiet_cycles = 0;

  always #5 clk = ~clk;

  second_order_state_observer_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  observer_estimate_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding),
    .checked_o        (checked),
    .predicted_state_o(predicted_state)
  );

  // Ends the run if no beat of any kind moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("** second_order_state_observer_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: spans of differing stall density, plus one long hold-off while the
  // sender keeps offering, so that the core fills and stalls its input.
  initial begin : receiver
    int hold_left;
    int span_left;
    int mode;
    bit long_hold_done;
    hold_left      = 0;
    span_left      = 0;
    mode           = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && samples_sent >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        if (span_left == 0) begin
          mode      = $urandom_range(0, 3);
          span_left = $urandom_range(5, 80);
        end
        span_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] clamp_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX[DATA_W-1:0];
    if (v < WORD_MIN) return WORD_MIN[DATA_W-1:0];
    return v[DATA_W-1:0];
  endfunction

  function automatic sso_in_t make_sample(input longint u, input longint y, input longint b);
    sso_in_t s;
    s.control_input = clamp_word(u);
    s.measurement   = clamp_word(y);
    s.input_gain    = clamp_word(b);
    return s;
  endfunction

  function automatic longint spread(input longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Leaves valid high on return; the caller lowers it or offers the next beat.
  task automatic send_sample(input sso_in_t sample);
    in_valid <= 1'b1;
    in_data  <= sample;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_estimates();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Sends one sample whose error z1 - y lands on the given value, then waits for it.
  task automatic aimed_sample(input longint u, input longint err, input longint b);
    send_sample(make_sample(u, longint'(predicted_state) - err, b));
    drain_estimates();
  endtask

  task automatic probe_sample(input longint u, input longint y, input longint b);
    send_sample(make_sample(u, y, b));
    drain_estimates();
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // A write to an unused index goes last, so a decoding fault would corrupt a gain.
  task automatic program_gains(input logic [DATA_W-1:0] state_gain,
                               input logic [DATA_W-1:0] dist_gain);
    write_register(CFG_STATE_GAIN, state_gain);
    write_register(CFG_DIST_GAIN, dist_gain);
    write_register(CFG_IDX_W'($urandom_range(CFG_DIST_GAIN + 1, (1 << CFG_IDX_W) - 1)),
                   $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] sg;
    logic [DATA_W-1:0] dg;
    sso_in_t           s;
    int                kind;
    int                run_left;
    int                burst_left;
    int                sent_here;
    longint            offset;
    bit                upward;
    kind       = 0;
    run_left   = 0;
    burst_left = 1;
    upward     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples under the reset gains, one at a time.
    aimed_sample(0, 0, 0);
    aimed_sample(UNIT, DELTA, UNIT);
    aimed_sample(UNIT, DELTA + 1, UNIT);
    aimed_sample(-UNIT, -DELTA, UNIT);
    aimed_sample(-UNIT, -DELTA - 1, UNIT);
    aimed_sample(0, 1, 0);
    aimed_sample(0, -1, 0);
    aimed_sample(2 * UNIT, 5 * UNIT, -3 * UNIT);
    probe_sample(WORD_MAX, WORD_MIN, WORD_MAX);
    probe_sample(WORD_MIN, WORD_MAX, WORD_MAX);
    probe_sample(WORD_MIN, WORD_MIN, WORD_MIN);
    probe_sample(WORD_MAX, WORD_MAX, WORD_MIN);
    probe_sample(0, WORD_MAX, WORD_MAX);
    probe_sample(longint'($signed(32'h5555_5555)), longint'($signed(32'hAAAA_AAAA)),
                 longint'($signed(32'h5555_5555)));
    probe_sample(longint'($signed(32'hAAAA_AAAA)), longint'($signed(32'h5555_5555)),
                 longint'($signed(32'hAAAA_AAAA)));
    probe_sample(-1, -1, -1);
    probe_sample(0, 0, 0);
    aimed_sample(0, 0, UNIT);

    for (int setting = 0; setting < SETTINGS_N; setting++) begin
      case (setting)
        0: begin sg = '0; dg = '0; end
        1: begin sg = 32'hFFFF_FFFF; dg = 32'hFFFF_FFFF; end
        2: begin sg = 32'(100 * UNIT); dg = 32'(300 * UNIT); end
        3: begin sg = 32'h7FFF_FFFF; dg = '0; end
        4: begin sg = '0; dg = 32'h7FFF_FFFF; end
        5: begin sg = $urandom; dg = $urandom; end
        default: begin
          sg = 32'($urandom_range(1, 600 * UNIT)) | ($urandom_range(0, 1) << 31);
          dg = 32'($urandom_range(1, 600 * UNIT)) | ($urandom_range(0, 1) << 31);
        end
      endcase
      drain_estimates();
      program_gains(sg, dg);

      sent_here = 0;
      while (sent_here < PER_SETTING) begin
        if (run_left == 0) begin
          kind   = $urandom_range(0, 9);
          upward = $urandom_range(0, 1);
          if (kind <= 5) begin
            run_left = $urandom_range(10, 60);
          end else if (kind <= 7) begin
            run_left = $urandom_range(20, 150);
          end else begin
            run_left = $urandom_range(1, 10);
          end
        end
        run_left--;
        if (kind <= 5) begin
          // Tracking: the measurement follows the estimate, half the time within 2 * delta.
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: offset = spread(2 * DELTA);
            5, 6, 7:       offset = spread(4 * UNIT);
            default:       offset = spread(1000 * UNIT);
          endcase
          s = make_sample(spread(4 * UNIT), longint'(predicted_state) - offset,
                          spread(4 * UNIT));
        end else if (kind <= 7) begin
          // Driving hard in one direction walks the estimates into saturation.
          s = make_sample(upward ? WORD_MAX : WORD_MIN, upward ? WORD_MIN : WORD_MAX,
                          WORD_MAX);
        end else begin
          s.control_input = $urandom;
          s.measurement   = $urandom;
          s.input_gain    = $urandom;
        end
        send_sample(s);
        sent_here++;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 60));
          burst_left = $urandom_range(1, 30);
        end
      end
    end

    drain_estimates();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d estimate beats from %0d sample beats over %0d gain settings,",
             checked, samples_sent, SETTINGS_N + 1);
    $display("including boundary errors around delta, saturation and stalls on both sides.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("** second_order_state_observer_core: PASSED **");
    end else begin
      $display("** second_order_state_observer_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sso_pkg.sv
hw/rtl/sso_sqrt.sv
hw/rtl/second_order_state_observer_core.sv
sim/observer_estimate_checker.sv
sim/second_order_state_observer_core_tb.sv
